@@ sv/pdd_pkg.sv @@
// pdd_pkg: shared types, constants and saturation helpers for the pid dirty derivative unit
// no dependencies

package pdd_pkg;

  localparam int unsigned ValueWidth = 48;
  localparam int unsigned GainWidth  = 32;
  localparam int unsigned DtWidth    = 24;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned OpWidth    = 64;
  localparam int unsigned ProdWidth  = 128;

  localparam logic [CfgIdxWidth-1:0] RegPropGain  = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegIntegGain = 8'd1;
  localparam logic [CfgIdxWidth-1:0] RegDerivGain = 8'd2;
  localparam logic [CfgIdxWidth-1:0] RegFilterTau = 8'd3;

  localparam logic [DtWidth-1:0] MinDtUs   = 24'd10;
  localparam logic [DtWidth-1:0] StaleDtUs = 24'd1000000;
  // 9999999 in Q32.16
  localparam logic signed [ValueWidth-1:0] ErrThr = 48'sd655359934464;
  localparam logic [OpWidth-1:0] TwoMega      = 64'd2000000;
  localparam logic [OpWidth-1:0] TwoMegaScale = 64'd131072000000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK,
    ST_P_GO, ST_P_WT,
    ST_T_GO, ST_T_WT,
    ST_F1_GO, ST_F1_WT,
    ST_F2_GO, ST_F2_WT,
    ST_FD_GO, ST_FD_WT,
    ST_D_GO, ST_D_WT,
    ST_E_GO, ST_E_WT,
    ST_ID_GO, ST_ID_WT,
    ST_I_GO, ST_I_WT,
    ST_FIN, ST_OUT
  } pdd_state_e;

  typedef struct packed {
    logic                 start;
    logic [OpWidth-1:0]   a;
    logic [OpWidth-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [ProdWidth-1:0] num;
    logic [OpWidth-1:0]   den;
  } div_req_t;

  function automatic logic signed [ValueWidth-1:0] sat_val(input logic [ProdWidth-1:0] x);
    logic signed [ValueWidth-1:0] r;
    if ((&x[ProdWidth-1:ValueWidth-1]) || !(|x[ProdWidth-1:ValueWidth-1])) begin
      r = x[ValueWidth-1:0];
    end else if (x[ProdWidth-1]) begin
      r = {1'b1, {(ValueWidth-1){1'b0}}};
    end else begin
      r = {1'b0, {(ValueWidth-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [OpWidth-1:0] sat_64(input logic [ProdWidth-1:0] x);
    logic signed [OpWidth-1:0] r;
    if ((&x[ProdWidth-1:OpWidth-1]) || !(|x[ProdWidth-1:OpWidth-1])) begin
      r = x[OpWidth-1:0];
    end else if (x[ProdWidth-1]) begin
      r = {1'b1, {(OpWidth-1){1'b0}}};
    end else begin
      r = {1'b0, {(OpWidth-1){1'b1}}};
    end
    return r;
  endfunction

  // gain product: floor shift by 16 then clamp
  function automatic logic signed [ValueWidth-1:0] gain_sat(input logic [ProdWidth-1:0] p);
    logic [ProdWidth-1:0] s;
    s = {{16{p[ProdWidth-1]}}, p[ProdWidth-1:16]};
    return sat_val(s);
  endfunction

endpackage

@@ sv/pid_dirty_derivative_unit.sv @@
// pid_dirty_derivative_unit: PID controller with trapezoidal integral and filtered derivative
// uses pdd_pkg, pdd_mul and pdd_div
//
// Usage: an input transaction (setpoint, measurement, elapsed time, optional rate) is
// taken when in_valid_i is high and in_stall_o is low; one drive transaction follows
// on the output channel, taken when out_valid_o is high and out_stall_i is low.
// Gains and filter tau are written on the cfg channel (cfg_ready_o is always high).
// Do so only while no transaction is in flight; the block does not enforce this.
// Flow: an item that is rejected (short time step or huge error) goes from the check
// straight to the output; otherwise the proportional product comes first, then the
// derivative (filter products and quotient, or the rate product) and the integral
// (product, quotient, product) as enabled. Products come from one serial multiplier,
// quotients from one serial divider; one item is worked at a time.
// The finished drive sits in an output register, so a new item is accepted while
// the receiver stalls; a second result waits until the first is taken.
// Reset clears all gains, the integral, the filter and the previous error/measurement.

module pid_dirty_derivative_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [pdd_pkg::ValueWidth-1:0] setpoint_i,
  input  logic signed [pdd_pkg::ValueWidth-1:0] measured_i,
  input  logic        [pdd_pkg::DtWidth-1:0]    elapsed_us_i,
  input  logic signed [pdd_pkg::ValueWidth-1:0] measured_rate_i,
  input  logic                                  rate_valid_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pdd_pkg::ValueWidth-1:0] drive_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [pdd_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic        [pdd_pkg::GainWidth-1:0]  cfg_data_i
);
  import pdd_pkg::*;

  pdd_state_e state_q, state_d;

  logic signed [GainWidth-1:0] kp_q, ki_q, kd_q;
  logic        [GainWidth-1:0] tau_q;

  logic signed [ValueWidth-1:0] sp_q, meas_q, rate_q, err_q;
  logic        [DtWidth-1:0]    dt_q;
  logic                         rate_ok_q;

  logic signed [ValueWidth-1:0] fd_q, prev_err_q, prev_meas_q;
  logic signed [OpWidth-1:0]    integ_q;
  logic signed [ValueWidth-1:0] p_q, d_q, it_q, res_q, drive_q;
  logic        [OpWidth-1:0]    tt_q;
  logic        [ProdWidth-1:0]  num_q;
  logic                         out_valid_q;

  mul_req_t             mul_req;
  div_req_t             div_req;
  logic                 mul_done, div_done;
  logic [ProdWidth-1:0] mul_prod, div_quot;

  logic                         in_take, out_take, kd_pos, ki_pos, reject, can_load;
  logic [ValueWidth:0]          err_raw, delta_raw, esum_raw;
  logic signed [ValueWidth-1:0] err, delta, esum;
  logic [OpWidth-1:0]           dd;
  logic [ProdWidth-1:0]         sum_p;
  pdd_state_e                   after_d;

  pdd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  pdd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign can_load = !out_valid_q || !out_stall_i;
  assign kd_pos   = !kd_q[GainWidth-1] && (|kd_q);
  assign ki_pos   = !ki_q[GainWidth-1] && (|ki_q);

  assign err_raw   = {sp_q[ValueWidth-1], sp_q} - {meas_q[ValueWidth-1], meas_q};
  assign err       = sat_val({{(ProdWidth-ValueWidth-1){err_raw[ValueWidth]}}, err_raw});
  assign delta_raw = {meas_q[ValueWidth-1], meas_q} - {prev_meas_q[ValueWidth-1], prev_meas_q};
  assign delta     = sat_val({{(ProdWidth-ValueWidth-1){delta_raw[ValueWidth]}}, delta_raw});
  assign esum_raw  = {err_q[ValueWidth-1], err_q} + {prev_err_q[ValueWidth-1], prev_err_q};
  assign esum      = sat_val({{(ProdWidth-ValueWidth-1){esum_raw[ValueWidth]}}, esum_raw});
  assign reject    = (dt_q < MinDtUs) || (err > ErrThr) || (err < -ErrThr);
  assign dd        = {{(OpWidth-DtWidth-16){1'b0}}, dt_q, 16'd0};
  assign after_d   = ki_pos ? ST_E_GO : ST_FIN;

  // p + i - d, each already within 48 bits
  assign sum_p = {{(ProdWidth-ValueWidth){p_q[ValueWidth-1]}}, p_q}
               + {{(ProdWidth-ValueWidth){it_q[ValueWidth-1]}}, it_q}
               - {{(ProdWidth-ValueWidth){d_q[ValueWidth-1]}}, d_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_take) state_d = ST_CHECK;
      ST_CHECK: state_d = reject ? ST_OUT : ST_P_GO;
      ST_P_GO:  state_d = ST_P_WT;
      ST_P_WT: begin
        if (mul_done) begin
          if (kd_pos && rate_ok_q) begin
            state_d = ST_D_GO;
          end else if (kd_pos && (|dt_q)) begin
            state_d = ST_T_GO;
          end else begin
            state_d = after_d;
          end
        end
      end
      ST_T_GO:  state_d = ST_T_WT;
      ST_T_WT:  if (mul_done) state_d = ST_F1_GO;
      ST_F1_GO: state_d = ST_F1_WT;
      ST_F1_WT: if (mul_done) state_d = ST_F2_GO;
      ST_F2_GO: state_d = ST_F2_WT;
      ST_F2_WT: if (mul_done) state_d = ST_FD_GO;
      ST_FD_GO: state_d = ST_FD_WT;
      ST_FD_WT: if (div_done) state_d = ST_D_GO;
      ST_D_GO:  state_d = ST_D_WT;
      ST_D_WT:  if (mul_done) state_d = after_d;
      ST_E_GO:  state_d = ST_E_WT;
      ST_E_WT:  if (mul_done) state_d = ST_ID_GO;
      ST_ID_GO: state_d = ST_ID_WT;
      ST_ID_WT: if (div_done) state_d = ST_I_GO;
      ST_I_GO:  state_d = ST_I_WT;
      ST_I_WT:  if (mul_done) state_d = ST_FIN;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT:   if (can_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // unit requests and handshake outputs
  always_comb begin
    mul_req       = '0;
    div_req       = '0;
    in_stall_o    = (state_q != ST_IDLE);
    case (state_q)
      ST_P_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(OpWidth-GainWidth){kp_q[GainWidth-1]}}, kp_q};
        mul_req.b     = {{(OpWidth-ValueWidth){err_q[ValueWidth-1]}}, err_q};
      end
      ST_T_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(OpWidth-GainWidth){1'b0}}, tau_q};
        mul_req.b     = TwoMega;
      end
      ST_F1_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = tt_q - dd;
        mul_req.b     = {{(OpWidth-ValueWidth){fd_q[ValueWidth-1]}}, fd_q};
      end
      ST_F2_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = TwoMegaScale;
        mul_req.b     = {{(OpWidth-ValueWidth){delta[ValueWidth-1]}}, delta};
      end
      ST_D_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(OpWidth-GainWidth){kd_q[GainWidth-1]}}, kd_q};
        mul_req.b     = rate_ok_q ? {{(OpWidth-ValueWidth){rate_q[ValueWidth-1]}}, rate_q}
                                  : {{(OpWidth-ValueWidth){fd_q[ValueWidth-1]}}, fd_q};
      end
      ST_E_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(OpWidth-DtWidth){1'b0}}, dt_q};
        mul_req.b     = {{(OpWidth-ValueWidth){esum[ValueWidth-1]}}, esum};
      end
      ST_I_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(OpWidth-GainWidth){ki_q[GainWidth-1]}}, ki_q};
        mul_req.b     = integ_q;
      end
      ST_FD_GO: begin
        div_req.start = 1'b1;
        div_req.num   = num_q;
        div_req.den   = tt_q + dd;
      end
      ST_ID_GO: begin
        div_req.start = 1'b1;
        div_req.num   = num_q;
        div_req.den   = TwoMega;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      tau_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPropGain:  kp_q  <= cfg_data_i;
        RegIntegGain: ki_q  <= cfg_data_i;
        RegDerivGain: kd_q  <= cfg_data_i;
        RegFilterTau: tau_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // loop state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_q        <= '0;
      prev_err_q  <= '0;
      prev_meas_q <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_CHECK && !reject && dt_q > StaleDtUs) begin
        fd_q <= '0;
      end
      if (state_q == ST_FD_WT && div_done) begin
        fd_q <= sat_val(div_quot);
      end
      if (state_q == ST_ID_WT && div_done) begin
        integ_q <= sat_64({{(ProdWidth-OpWidth){integ_q[OpWidth-1]}}, integ_q} + div_quot);
      end
      if (state_q == ST_FIN) begin
        prev_err_q  <= err_q;
        prev_meas_q <= meas_q;
      end
      if (state_q == ST_OUT && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sp_q      <= setpoint_i;
      meas_q    <= measured_i;
      dt_q      <= elapsed_us_i;
      rate_q    <= measured_rate_i;
      rate_ok_q <= rate_valid_i;
    end
    case (state_q)
      ST_CHECK: begin
        err_q <= err;
        d_q   <= '0;
        it_q  <= '0;
        res_q <= '0;
        // stale loop: elapsed time taken as zero
        if (dt_q > StaleDtUs) dt_q <= '0;
      end
      ST_P_WT:  if (mul_done) p_q <= gain_sat(mul_prod);
      ST_T_WT:  if (mul_done) tt_q <= mul_prod[OpWidth-1:0];
      ST_F1_WT: if (mul_done) num_q <= mul_prod;
      ST_F2_WT: if (mul_done) num_q <= num_q + mul_prod;
      ST_D_WT:  if (mul_done) d_q <= gain_sat(mul_prod);
      ST_E_WT:  if (mul_done) num_q <= mul_prod;
      ST_I_WT:  if (mul_done) it_q <= gain_sat(mul_prod);
      ST_FIN:   res_q <= sat_val(sum_p);
      ST_OUT:   if (can_load) drive_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign cfg_ready_o = 1'b1;

`ifndef ASSERT_OFF
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> state_q == ST_IDLE)
    else $error("input transaction taken while busy");

  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_P_WT || state_q == ST_T_WT || state_q == ST_F1_WT ||
                  state_q == ST_F2_WT || state_q == ST_D_WT || state_q == ST_E_WT ||
                  state_q == ST_I_WT))
    else $error("multiplier finished outside a wait state");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_FD_WT || state_q == ST_ID_WT))
    else $error("divider finished outside a wait state");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("drive presented without a finished item");
`endif

endmodule

@@ sv/pdd_mul.sv @@
// pdd_mul: signed 64x64 multiplier, shift-and-add one multiplier bit per cycle
// depends on pdd_pkg

module pdd_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pdd_pkg::mul_req_t           req_i,
  output logic                        done_o,
  output logic [pdd_pkg::ProdWidth-1:0] prod_o
);
  import pdd_pkg::*;

  logic                 busy_q, done_q, neg_q;
  logic [5:0]           cnt_q;
  logic [OpWidth-1:0]   mcand_q;
  logic [ProdWidth-1:0] p_q;
  logic [OpWidth:0]     sum;
  logic [OpWidth-1:0]   a_mag, b_mag;

  assign a_mag = req_i.a[OpWidth-1] ? (~req_i.a + 64'd1) : req_i.a;
  assign b_mag = req_i.b[OpWidth-1] ? (~req_i.b + 64'd1) : req_i.b;
  assign sum = {1'b0, p_q[ProdWidth-1:OpWidth]} + (p_q[0] ? {1'b0, mcand_q} : 65'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= a_mag;
      p_q     <= {{OpWidth{1'b0}}, b_mag};
      neg_q   <= req_i.a[OpWidth-1] ^ req_i.b[OpWidth-1];
    end else if (busy_q) begin
      p_q <= {sum, p_q[OpWidth-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? (~p_q + 128'd1) : p_q;

endmodule

@@ sv/pdd_div.sv @@
// pdd_div: signed 128-bit by unsigned divisor, restoring, one quotient bit per cycle
// quotient truncates toward zero; depends on pdd_pkg

module pdd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pdd_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [pdd_pkg::ProdWidth-1:0] quot_o
);
  import pdd_pkg::*;

  logic                 busy_q, done_q, neg_q;
  logic [6:0]           cnt_q;
  logic [ProdWidth-1:0] u_q;
  logic [OpWidth-1:0]   rem_q, den_q, r2;
  logic                 ge;

  assign r2 = {rem_q[OpWidth-2:0], u_q[ProdWidth-1]};
  assign ge = (r2 >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      u_q   <= req_i.num[ProdWidth-1] ? (~req_i.num + 128'd1) : req_i.num;
      neg_q <= req_i.num[ProdWidth-1];
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (r2 - den_q) : r2;
      u_q   <= {u_q[ProdWidth-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~u_q + 128'd1) : u_q;

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for pid_dirty_derivative_unit
// holds a drive predictor in a scoreboard class; depends on pdd_pkg and the unit rtl
`timescale 1ns / 1ps

module tb_top;
  import pdd_pkg::*;

  localparam logic [CfgIdxWidth-1:0] RegUnused = 8'd4;
  localparam int unsigned WatchLimit = 40000;
  localparam int unsigned RandPerPhase = 240;

  typedef logic signed [ProdWidth-1:0] wide_t;

  class drive_scoreboard;
    logic signed [63:0]           integ_acc;
    logic signed [ValueWidth-1:0] deriv_filt;
    logic signed [ValueWidth-1:0] last_err;
    logic signed [ValueWidth-1:0] last_meas;
    logic signed [GainWidth-1:0]  kp, ki, kd;
    logic        [GainWidth-1:0]  tau;
    logic signed [ValueWidth-1:0] drive_q[$];
    int fails;

    function new();
      integ_acc = 0; deriv_filt = 0; last_err = 0; last_meas = 0;
      kp = 0; ki = 0; kd = 0; tau = 0; fails = 0;
    endfunction

    function wide_t clamp(wide_t x, int w);
      wide_t hi_lim, lo_lim;
      hi_lim = (wide_t'(1) <<< (w - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (x > hi_lim) return hi_lim;
      if (x < lo_lim) return lo_lim;
      return x;
    endfunction

    function wide_t scale_gain(logic signed [GainWidth-1:0] g, wide_t v);
      wide_t gw;
      gw = g;
      return clamp((gw * v) >>> 16, ValueWidth);
    endfunction

    function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [GainWidth-1:0] val);
      case (idx)
        RegPropGain:  kp = val;
        RegIntegGain: ki = val;
        RegDerivGain: kd = val;
        RegFilterTau: tau = val;
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [ValueWidth-1:0] sp,
                             logic signed [ValueWidth-1:0] meas,
                             logic [DtWidth-1:0] dt,
                             logic signed [ValueWidth-1:0] rate,
                             logic rv);
      wide_t err, thr, dtw, p, d, it, tt, dd, delta, num, esum, inc, ws, wm, tw;
      ws = sp;
      wm = meas;
      err = clamp(ws - wm, ValueWidth);
      thr = wide_t'(9999999) * 65536;
      if (dt < 10 || err > thr || err < -thr) begin
        drive_q.push_back('0);
        return;
      end
      dtw = $signed({104'd0, dt});
      if (dt > 1000000) begin
        dtw = 0;
        deriv_filt = 0;
      end
      p = scale_gain(kp, err);
      d = 0;
      it = 0;
      if (kd > 0) begin
        if (rv) begin
          d = scale_gain(kd, wide_t'(rate));
        end else if (dtw > 0) begin
          tw = $signed({96'd0, tau});
          tt = tw * 2000000;
          dd = dtw * 65536;
          delta = clamp(wm - wide_t'(last_meas), ValueWidth);
          num = (tt - dd) * wide_t'(deriv_filt) + wide_t'(TwoMegaScale) * delta;
          deriv_filt = ValueWidth'(clamp(num / (tt + dd), ValueWidth));
          d = scale_gain(kd, wide_t'(deriv_filt));
        end
      end
      if (ki > 0) begin
        esum = clamp(err + wide_t'(last_err), ValueWidth);
        inc = (dtw * esum) / 2000000;
        integ_acc = 64'(clamp(wide_t'(integ_acc) + inc, 64));
        it = scale_gain(ki, wide_t'(integ_acc));
      end
      last_err = ValueWidth'(err);
      last_meas = meas;
      drive_q.push_back(ValueWidth'(clamp(p + it - d, ValueWidth)));
    endfunction

    function void check_drive(logic signed [ValueWidth-1:0] act);
      logic signed [ValueWidth-1:0] exp_v;
      if (drive_q.size() == 0) begin
        $error("drive: no transaction expected, actual %0d", act);
        fails++;
        return;
      end
      exp_v = drive_q.pop_front();
      if (act !== exp_v) begin
        $error("drive mismatch: expected %0d actual %0d", exp_v, act);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic signed [ValueWidth-1:0] setpoint, measured, meas_rate, drive;
  logic [DtWidth-1:0] elapsed;
  logic rate_ok;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [GainWidth-1:0] cfg_data;
  logic calm;
  int unsigned quiet_cycles;

  drive_scoreboard sb = new();

  pid_dirty_derivative_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .setpoint_i(setpoint), .measured_i(measured), .elapsed_us_i(elapsed),
    .measured_rate_i(meas_rate), .rate_valid_i(rate_ok),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .drive_o(drive),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accepted transactions feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(setpoint, measured, elapsed, meas_rate, rate_ok);
      if (out_valid && !out_stall) sb.check_drive(drive);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
          sb.drive_q.size() == 0)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  function automatic logic signed [ValueWidth-1:0] rand_val();
    logic signed [ValueWidth-1:0] v;
    v = ValueWidth'({$urandom, $urandom});
    return v >>> $urandom_range(47);
  endfunction

  task automatic send_item(logic signed [ValueWidth-1:0] sp, logic signed [ValueWidth-1:0] ms,
                           logic [DtWidth-1:0] dt, logic signed [ValueWidth-1:0] rt, logic rv);
    logic s;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    setpoint <= sp;
    measured <= ms;
    elapsed <= dt;
    meas_rate <= rt;
    rate_ok <= rv;
    do begin
      @(negedge clk);
      s = in_stall;
      @(posedge clk);
    end while (s);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [GainWidth-1:0] val);
    logic r;
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [31:0] t);
    wait_idle();
    write_reg(RegPropGain, p);
    write_reg(RegIntegGain, i);
    write_reg(RegDerivGain, d);
    write_reg(RegFilterTau, t);
  endtask

  task automatic random_items(int n);
    logic signed [ValueWidth-1:0] ms, sp;
    logic [DtWidth-1:0] dt;
    int k, pick;
    for (k = 0; k < n; k++) begin
      calm = (k >= n / 3 && k < n / 2);
      ms = rand_val();
      pick = $urandom_range(99);
      // mostly errors inside the accepted window
      if (pick < 85) sp = ms + (rand_val() >>> $urandom_range(12, 20));
      else sp = ValueWidth'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 75) dt = DtWidth'($urandom_range(10, 20000));
      else if (pick < 82) dt = DtWidth'($urandom_range(0, 9));
      else if (pick < 90) dt = DtWidth'($urandom_range(1000001, 16777215));
      else dt = DtWidth'($urandom_range(20001, 1000000));
      send_item(sp, ms, dt, rand_val(), 1'($urandom_range(1)));
    end
    calm = 1'b0;
  endtask

  initial begin
    logic signed [ValueWidth-1:0] vmax, vmin, thr;
    int ph;
    vmax = {1'b0, {(ValueWidth-1){1'b1}}};
    vmin = {1'b1, {(ValueWidth-1){1'b0}}};
    thr = 48'sd655359934464;
    rst_n = 1'b0;
    in_valid = 1'b0; setpoint = '0; measured = '0; elapsed = '0; meas_rate = '0; rate_ok = 1'b0;
    out_stall = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    calm = 1'b0; quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(RegUnused, 32'hdead_beef);
    load_gains(32'h0001_8000, 32'h0000_4000, 32'h0000_2000, 32'h0000_0100);
    // directed: time step edges, error threshold, saturating values
    send_item(48'sd100000, 48'sd0, 24'd0, 48'sd0, 1'b0);
    send_item(48'sd100000, 48'sd0, 24'd9, 48'sd0, 1'b0);
    send_item(48'sd100000, 48'sd0, 24'd10, 48'sd0, 1'b0);
    send_item(48'sd5000, 48'sd90000, 24'd1000, 48'sd0, 1'b0);
    send_item(48'sd5000, 48'sd70000, 24'd1000000, 48'sd0, 1'b0);
    send_item(48'sd5000, 48'sd60000, 24'd1000001, 48'sd0, 1'b0);
    send_item(48'sd5000, 48'sd50000, 24'd16777215, 48'sd0, 1'b0);
    send_item(thr, 48'sd0, 24'd500, 48'sd0, 1'b0);
    send_item(thr + 1, 48'sd0, 24'd500, 48'sd0, 1'b0);
    send_item(-thr, 48'sd0, 24'd500, vmax, 1'b1);
    send_item(-thr - 1, 48'sd0, 24'd500, vmax, 1'b1);
    send_item(vmax, vmin, 24'd500, 48'sd0, 1'b0);
    send_item(vmin, vmax, 24'd500, 48'sd0, 1'b0);
    send_item(vmax, vmax, 24'd500, vmin, 1'b1);
    send_item(vmin, vmin, 24'd500, vmax, 1'b1);
    send_item(vmax - 48'sd1000, vmax, 24'd2000, 48'sd0, 1'b0);
    send_item(48'sd0, 48'sd0, 24'd2000, -48'sd1, 1'b1);
    load_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(thr, 48'sd0, 24'd1000000, vmax, 1'b1);
    send_item(thr, vmin + thr, 24'd999999, 48'sd0, 1'b0);
    send_item(-thr, 48'sd0, 24'd10, 48'sd0, 1'b0);
    send_item(vmax, vmax - thr, 24'd10, vmin, 1'b1);
    load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    send_item(thr, 48'sd0, 24'd10, 48'sd0, 1'b0);
    send_item(-thr, 48'sd0, 24'd777, vmin, 1'b1);
    load_gains(32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'h0000_0000);
    send_item(48'sd300, 48'sd4000, 24'd50, 48'sd0, 1'b0);
    send_item(48'sd300, 48'sd9000, 24'd50, 48'sd0, 1'b0);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_gains(32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_0020);
        1: load_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
        2: load_gains(32'h8000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0000);
        default: load_gains($urandom, $urandom >> $urandom_range(1), $urandom >> $urandom_range(1),
                            $urandom >> $urandom_range(31));
      endcase
      random_items(RandPerPhase);
    end
    wait_idle();

    if (sb.fails == 0 && sb.drive_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ pid_dirty_derivative_unit.f @@
sv/pdd_pkg.sv
sv/pdd_mul.sv
sv/pdd_div.sv
sv/pid_dirty_derivative_unit.sv
bench/tb_top.sv
